// File: rtl/rrts_pkg.sv
// ----------------------------------------------------------------------------
// rrts_pkg - round-robin task scheduler definitions
// Command, status and register index codes plus fixed field widths.
// ----------------------------------------------------------------------------
package rrts_pkg;

  // field widths fixed by the interface
  localparam int CMD_W    = 2;
  localparam int ID_W     = 4;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W    = 16;
  localparam int FRAC_W   = 17;
  localparam int SEC_W    = 32;

  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // commands
  localparam cmd_t CMD_TICK  = 2'd0;
  localparam cmd_t CMD_SPAWN = 2'd1;
  localparam cmd_t CMD_DIE   = 2'd2;

  // result status
  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_FULL = 2'd1;
  localparam status_t ST_BAD  = 2'd2;

  // configuration register indexes
  localparam cfg_idx_t REG_TICK_STEP    = 2'd0;
  localparam cfg_idx_t REG_UNITS_PER_SEC = 2'd1;

  // reset values of the configuration registers
  localparam logic [CFG_W-1:0] TICK_STEP_RST = 16'd1;
  localparam logic [CFG_W-1:0] UPS_RST       = 16'd1000;

endpackage

// File: rtl/round_robin_task_scheduler.sv
// ----------------------------------------------------------------------------
// round_robin_task_scheduler - ring-based round-robin task scheduler
// Doubly linked ring of tasks behind a root entry, slot allocation with a
// circular free-slot search, and a fractional tick counter yielding seconds.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  in_     | input     | in_valid/in_stall  | cmd, task_id, task_is_root
//  out_    | output    | out_valid/out_stall| next_task, next_is_root, new_slot,
//          |           |                    | status, seconds
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  Every beat is accepted in idle and walks the sequencer: tick reads,
//  unlinks and relinks the task at the tail; die reads, unlinks and clears;
//  spawn scans for a free slot (free-slot scan checks one slot per cycle),
//  claims it and links it in; every command ends with the head read and output.
//  The link memories have one write and one registered read port each; every
//  link update is a step of the sequencer through those ports.
//  Reset (rst_n low, synchronous) clears control, counters and the link
//  valid bits; an unwritten link entry reads as the root, so no sweep.
//  A held result in the output register does not block the next input beat;
//  the sequencer waits only when it has a new result and the old one stalls.
//
module round_robin_task_scheduler
  import rrts_pkg::*;
#(
  parameter int SLOT_COUNT = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  // command channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CMD_W-1:0]    in_cmd,
  input  logic [ID_W-1:0]     in_task_id,
  input  logic                in_task_is_root,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [ID_W-1:0]     out_next_task,
  output logic                out_next_is_root,
  output logic [ID_W-1:0]     out_new_slot,
  output logic [STATUS_W-1:0] out_status,
  output logic [SEC_W-1:0]    out_seconds,
  // configuration write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]    cfg_data
);

  localparam int RING_SIZE = SLOT_COUNT + 1;
  localparam int RW        = $clog2(RING_SIZE);   // ring index width
  localparam int SW        = $clog2(SLOT_COUNT);  // slot index width
  localparam logic [RW-1:0] ROOT     = RW'(SLOT_COUNT);
  localparam logic [SW-1:0] LAST_SLT = SW'(SLOT_COUNT - 1);

  // sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_TK_RD    = 4'd1;
  localparam logic [3:0] S_TK_UNL   = 4'd2;
  localparam logic [3:0] S_TK_TAIL  = 4'd3;
  localparam logic [3:0] S_TK_LINK  = 4'd4;
  localparam logic [3:0] S_TK_LINK2 = 4'd5;
  localparam logic [3:0] S_SCAN     = 4'd6;
  localparam logic [3:0] S_SP_RD    = 4'd7;
  localparam logic [3:0] S_SP_LNK   = 4'd8;
  localparam logic [3:0] S_SP_LNK2  = 4'd9;
  localparam logic [3:0] S_DIE_RD   = 4'd10;
  localparam logic [3:0] S_DIE_UNL  = 4'd11;
  localparam logic [3:0] S_DIE_CLR  = 4'd12;
  localparam logic [3:0] S_HEAD     = 4'd13;
  localparam logic [3:0] S_OUT      = 4'd14;

  // link memories
  logic [RW-1:0] next_mem [RING_SIZE];
  logic [RW-1:0] prev_mem [RING_SIZE];
  logic [RING_SIZE-1:0] n_vld_r, p_vld_r;
  logic [RW-1:0] n_rdata_r, p_rdata_r;
  logic          n_rvld_r, p_rvld_r;
  logic          n_we, p_we;
  logic [RW-1:0] n_wa, n_wd, n_ra, p_wa, p_wd, p_ra;
  logic [RW-1:0] n_rd, p_rd;

  // control and state
  logic [3:0]           state_r, state_nxt;
  logic                 live_r, live_nxt;
  logic [SW-1:0]        t_r, t_nxt;
  logic [SW-1:0]        s_r, s_nxt;
  logic [SW-1:0]        k_r, k_nxt;
  logic [SW-1:0]        cursor_r, cursor_nxt;
  logic [SLOT_COUNT-1:0] used_r, used_nxt;
  logic [RW-1:0]        tail_r, tail_nxt;
  logic [FRAC_W-1:0]    frac_r, frac_nxt;
  logic [SEC_W-1:0]     sec_r, sec_nxt;
  logic [STATUS_W-1:0]  status_r, status_nxt;
  logic [ID_W-1:0]      new_slot_r, new_slot_nxt;
  logic [CFG_W-1:0]     tick_step_r, ups_r;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]      out_task_r, out_task_nxt;
  logic                 out_root_r, out_root_nxt;
  logic [ID_W-1:0]      out_slot_r, out_slot_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [SEC_W-1:0]     out_sec_r, out_sec_nxt;

  logic                 in_take;
  logic                 id_live;
  logic [SW-1:0]        id_slot;

  // ---------------------------------------------------------------------------
  // link memories: one write, one registered read each
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (n_we) begin
      next_mem[n_wa] <= n_wd;
    end
    if (p_we) begin
      prev_mem[p_wa] <= p_wd;
    end
    n_rdata_r <= next_mem[n_ra];
    p_rdata_r <= prev_mem[p_ra];
  end

  // per-entry valid bits; an entry never written links to the root
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_vld_r  <= '0;
      p_vld_r  <= '0;
      n_rvld_r <= 1'b0;
      p_rvld_r <= 1'b0;
    end else begin
      n_rvld_r <= n_vld_r[n_ra];
      p_rvld_r <= p_vld_r[p_ra];
      if (n_we) begin
        n_vld_r[n_wa] <= 1'b1;
      end
      if (p_we) begin
        p_vld_r[p_wa] <= 1'b1;
      end
    end
  end

  assign n_rd = n_rvld_r ? n_rdata_r : ROOT;
  assign p_rd = p_rvld_r ? p_rdata_r : ROOT;

  // ---------------------------------------------------------------------------
  // handshake and decode
  // ---------------------------------------------------------------------------
  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign id_slot = SW'(in_task_id);
  assign id_live = !in_task_is_root && (int'(in_task_id) < SLOT_COUNT) && used_r[id_slot];

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt    = state_r;
    live_nxt     = live_r;
    t_nxt        = t_r;
    s_nxt        = s_r;
    k_nxt        = k_r;
    cursor_nxt   = cursor_r;
    used_nxt     = used_r;
    tail_nxt     = tail_r;
    frac_nxt     = frac_r;
    sec_nxt      = sec_r;
    status_nxt   = status_r;
    new_slot_nxt = new_slot_r;

    out_valid_nxt  = out_valid_r;
    out_task_nxt   = out_task_r;
    out_root_nxt   = out_root_r;
    out_slot_nxt   = out_slot_r;
    out_status_nxt = out_status_r;
    out_sec_nxt    = out_sec_r;

    n_we = 1'b0;
    n_wa = ROOT;
    n_wd = ROOT;
    n_ra = ROOT;
    p_we = 1'b0;
    p_wa = ROOT;
    p_wd = ROOT;
    p_ra = ROOT;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          live_nxt     = id_live;
          t_nxt        = id_slot;
          s_nxt        = cursor_r;
          k_nxt        = '0;
          status_nxt   = ST_OK;
          new_slot_nxt = '0;
          case (in_cmd)
            CMD_TICK:  state_nxt = S_TK_RD;
            CMD_SPAWN: state_nxt = S_SCAN;
            CMD_DIE: begin
              state_nxt = S_DIE_RD;
              if (!id_live) begin
                status_nxt = ST_BAD;
              end
            end
            default:   state_nxt = S_HEAD;
          endcase
        end
      end

      // tick: time step 1 and fetch links of the task that ran
      S_TK_RD: begin
        frac_nxt  = frac_r + FRAC_W'(tick_step_r);
        n_ra      = RW'(t_r);
        p_ra      = RW'(t_r);
        state_nxt = S_TK_UNL;
      end
      // time step 2, unlink the task
      S_TK_UNL: begin
        if (frac_r >= FRAC_W'(ups_r)) begin
          frac_nxt = frac_r - FRAC_W'(ups_r);
          sec_nxt  = sec_r + SEC_W'(1);
        end
        n_we      = live_r;
        n_wa      = p_rd;
        n_wd      = n_rd;
        p_we      = live_r;
        p_wa      = n_rd;
        p_wd      = p_rd;
        state_nxt = S_TK_TAIL;
      end
      // read the tail once the unlink has landed
      S_TK_TAIL: begin
        state_nxt = S_TK_LINK;
      end
      S_TK_LINK: begin
        tail_nxt  = p_rd;
        n_we      = live_r;
        n_wa      = p_rd;
        n_wd      = RW'(t_r);
        p_we      = live_r;
        p_wa      = ROOT;
        p_wd      = RW'(t_r);
        state_nxt = S_TK_LINK2;
      end
      S_TK_LINK2: begin
        n_we      = live_r;
        n_wa      = RW'(t_r);
        n_wd      = ROOT;
        p_we      = live_r;
        p_wa      = RW'(t_r);
        p_wd      = tail_r;
        state_nxt = S_HEAD;
      end

      // spawn: one slot checked per cycle
      S_SCAN: begin
        if (!used_r[s_r]) begin
          state_nxt = S_SP_RD;
        end else if (k_r == LAST_SLT) begin
          status_nxt = ST_FULL;
          state_nxt  = S_HEAD;
        end else begin
          s_nxt = (s_r == LAST_SLT) ? '0 : s_r + SW'(1);
          k_nxt = k_r + SW'(1);
        end
      end
      // claim the slot, fetch the first task after the root
      S_SP_RD: begin
        cursor_nxt      = s_r;
        used_nxt[s_r]   = 1'b1;
        new_slot_nxt    = ID_W'(s_r);
        state_nxt       = S_SP_LNK;
      end
      S_SP_LNK: begin
        n_we      = 1'b1;
        n_wa      = RW'(s_r);
        n_wd      = n_rd;
        p_we      = 1'b1;
        p_wa      = n_rd;
        p_wd      = RW'(s_r);
        state_nxt = S_SP_LNK2;
      end
      S_SP_LNK2: begin
        n_we      = 1'b1;
        n_wa      = ROOT;
        n_wd      = RW'(s_r);
        p_we      = 1'b1;
        p_wa      = RW'(s_r);
        p_wd      = ROOT;
        state_nxt = S_HEAD;
      end

      // die: unlink and free
      S_DIE_RD: begin
        n_ra      = RW'(t_r);
        p_ra      = RW'(t_r);
        state_nxt = S_DIE_UNL;
      end
      S_DIE_UNL: begin
        n_we      = live_r;
        n_wa      = p_rd;
        n_wd      = n_rd;
        p_we      = live_r;
        p_wa      = n_rd;
        p_wd      = p_rd;
        state_nxt = S_DIE_CLR;
      end
      S_DIE_CLR: begin
        n_we      = live_r;
        n_wa      = RW'(t_r);
        n_wd      = ROOT;
        p_we      = live_r;
        p_wa      = RW'(t_r);
        p_wd      = ROOT;
        if (live_r) begin
          used_nxt[t_r] = 1'b0;
        end
        state_nxt = S_HEAD;
      end

      // head read: next[root] is on the default read address
      S_HEAD: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_root_nxt   = (n_rd == ROOT);
          out_task_nxt   = (n_rd == ROOT) ? '0 : ID_W'(n_rd);
          out_slot_nxt   = new_slot_r;
          out_status_nxt = status_r;
          out_sec_nxt    = sec_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cursor_r    <= '0;
      used_r      <= '0;
      frac_r      <= '0;
      sec_r       <= '0;
      out_valid_r <= 1'b0;
      tick_step_r <= TICK_STEP_RST;
      ups_r       <= UPS_RST;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      used_r      <= used_nxt;
      frac_r      <= frac_nxt;
      sec_r       <= sec_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TICK_STEP:     tick_step_r <= cfg_data;
          REG_UNITS_PER_SEC: ups_r       <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    live_r       <= live_nxt;
    t_r          <= t_nxt;
    s_r          <= s_nxt;
    k_r          <= k_nxt;
    tail_r       <= tail_nxt;
    status_r     <= status_nxt;
    new_slot_r   <= new_slot_nxt;
    out_task_r   <= out_task_nxt;
    out_root_r   <= out_root_nxt;
    out_slot_r   <= out_slot_nxt;
    out_status_r <= out_status_nxt;
    out_sec_r    <= out_sec_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_next_task    = out_task_r;
  assign out_next_is_root = out_root_r;
  assign out_new_slot     = out_slot_r;
  assign out_status       = out_status_r;
  assign out_seconds      = out_sec_r;

`ifndef NO_ASSERTIONS
  // a new result only comes from the final sequencer step
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result raised outside final step");

  // a full ring never reports a slot
  a_full_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_FULL) |-> (out_slot_r == '0))
    else $error("full status with nonzero slot");

  // a claimed slot is marked used in the next cycle
  a_claim_used: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SP_RD) |=> used_r[s_r])
    else $error("claimed slot not marked used");

  // an accepted beat always starts the sequencer
  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> (state_r != S_IDLE))
    else $error("accepted beat left sequencer idle");
`endif

endmodule
